>>> rtl/assert_macros.svh
// assertion helpers for the rolling hash engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);

`endif

>>> rtl/prh_pkg.sv
`timescale 1ns / 1ps
package prh_pkg;

   localparam int MAX_LEN = 1024;
   localparam int HASH_W  = 30;
   localparam int IDX_W   = 10;
   localparam int LEN_W   = 11;
   localparam int CNT_W   = 5;

   localparam logic [HASH_W-1:0] MODULUS      = 30'd1000000007;
   localparam logic [31:0]       MODULUS_X2   = 32'd2000000014;
   localparam logic [HASH_W-1:0] BASE_RESET   = 30'd31;
   localparam logic [HASH_W-1:0] INV_RESET    = 30'd129032259;
   localparam logic [7:0]        SYM_FIRST    = 8'd97;
   localparam logic [7:0]        SYM_LAST     = 8'd122;
   localparam logic [7:0]        SYM_OFFSET   = 8'd96;
   localparam logic [CNT_W-1:0]  MUL_LAST     = 5'd29;
   localparam logic [LEN_W-1:0]  LEN_FULL     = 11'd1024;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic REG_HASH_BASE = 1'b0;
   localparam logic REG_BASE_INV  = 1'b1;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_RANGE  = 2'd1,
      OP_MERGE  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      FS_IDLE, FS_A_RD, FS_A_PW, FS_A_WPW, FS_A_WIV, FS_A_MV, FS_A_WV,
      FS_R_START, FS_R_HI, FS_R_LO, FS_R_INV, FS_R_MUL, FS_R_WAIT,
      FS_M_POW, FS_M_PRD, FS_M_WPW, FS_M_MUL, FS_M_WAIT, FS_DONE
   } fsm_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [7:0]       symbol;
      logic             restart;
      logic [IDX_W-1:0] left_a;
      logic [IDX_W-1:0] right_a;
      logic [IDX_W-1:0] left_b;
      logic [IDX_W-1:0] right_b;
   } req_item_type;

   typedef struct packed {
      logic [HASH_W-1:0] hash_value;
      logic [IDX_W-1:0]  position;
      logic [1:0]        status;
   } rsp_item_type;

   typedef struct packed {
      logic [HASH_W-1:0] prefix;
      logic [HASH_W-1:0] power;
      logic [HASH_W-1:0] inverse;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      logic [IDX_W-1:0] raddr;
   } store_ctl_type;

   function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
      logic [HASH_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MODULUS}) begin
         s = s - {1'b0, MODULUS};
      end
      return s[HASH_W-1:0];
   endfunction

   function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b);
      logic [HASH_W:0] s;
      if (a >= b) begin
         s = {1'b0, a} - {1'b0, b};
      end else begin
         s = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
      end
      return s[HASH_W-1:0];
   endfunction

   function automatic logic [HASH_W-1:0] reduce(input logic [HASH_W-1:0] a);
      return (a >= MODULUS) ? a - MODULUS : a;
   endfunction

endpackage

>>> rtl/prh_store.sv
`timescale 1ns / 1ps
module prh_store (
   input  logic                   clock,
   input  prh_pkg::store_ctl_type ctl,
   input  prh_pkg::entry_type     wdata,
   output prh_pkg::entry_type     rdata
);

   logic [prh_pkg::HASH_W-1:0] pfx_mem [prh_pkg::MAX_LEN];
   logic [prh_pkg::HASH_W-1:0] pow_mem [prh_pkg::MAX_LEN];
   logic [prh_pkg::HASH_W-1:0] inv_mem [prh_pkg::MAX_LEN];

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         pfx_mem[ctl.waddr] <= wdata.prefix;
         pow_mem[ctl.waddr] <= wdata.power;
         inv_mem[ctl.waddr] <= wdata.inverse;
      end
      rdata.prefix  <= pfx_mem[ctl.raddr];
      rdata.power   <= pow_mem[ctl.raddr];
      rdata.inverse <= inv_mem[ctl.raddr];
   end

endmodule

>>> rtl/prh_modmul.sv
`timescale 1ns / 1ps
module prh_modmul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [prh_pkg::HASH_W-1:0] op_a,
   input  logic [prh_pkg::HASH_W-1:0] op_b,
   output logic [prh_pkg::HASH_W-1:0] result,
   output logic                       done
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [prh_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [prh_pkg::HASH_W-1:0] acc_ff, acc_in;
   logic [prh_pkg::HASH_W-1:0] a_ff, a_in;
   logic [prh_pkg::HASH_W-1:0] b_ff, b_in;
   logic [31:0]                t;
   logic [31:0]                r;

   always_comb begin
      t = {1'b0, acc_ff, 1'b0} + (b_ff[prh_pkg::HASH_W-1] ? {2'b00, a_ff} : 32'd0);
      if (t >= prh_pkg::MODULUS_X2) begin
         r = t - prh_pkg::MODULUS_X2;
      end else if (t >= {2'b00, prh_pkg::MODULUS}) begin
         r = t - {2'b00, prh_pkg::MODULUS};
      end else begin
         r = t;
      end
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         acc_in = r[prh_pkg::HASH_W-1:0];
         b_in   = {b_ff[prh_pkg::HASH_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == prh_pkg::MUL_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign result = acc_ff;
   assign done   = done_ff;

endmodule

>>> rtl/prefix_rolling_hash_engine.sv
`timescale 1ns / 1ps
// channel   handshake                  payload
// req       req_valid / req_stall      req_item (prh_pkg::req_item_type)
// rsp       rsp_valid / rsp_stall      rsp_item (prh_pkg::rsp_item_type)
// csr       csr_write_en               csr_index, csr_wdata
// one item at a time; each modular multiply runs in the shift-add unit (prh_modmul)
// append: three multiplies (power, inverse, value), only the value multiply at position zero
// range: one multiply, merge: up to four; an empty range skips its multiply
// rejected items go straight from accept to FS_DONE; store reads are registered
// a finished item waits in the output register while the next item is taken
// reset clears length and control; store contents stay undefined until appended
`include "assert_macros.svh"
module prefix_rolling_hash_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  prh_pkg::req_item_type       req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output prh_pkg::rsp_item_type       rsp_item,
   input  logic                        csr_write_en,
   input  logic                        csr_index,
   input  logic [prh_pkg::HASH_W-1:0]  csr_wdata
);

   localparam int HW = prh_pkg::HASH_W;
   localparam int IW = prh_pkg::IDX_W;
   localparam int LW = prh_pkg::LEN_W;

   prh_pkg::fsm_type      fsm_ff, fsm_in;
   prh_pkg::req_item_type item_ff, item_in;
   prh_pkg::rsp_item_type rsp_item_ff, rsp_item_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]         len_ff, len_in;
   logic [LW-1:0]         n1_ff, n1_in;
   logic [IW-1:0]         pos_ff, pos_in;
   logic [1:0]            status_ff, status_in;
   logic [HW-1:0]         hash_ff, hash_in;
   logic [HW-1:0]         hi_ff, hi_in;
   logic [HW-1:0]         lo_ff, lo_in;
   logic [HW-1:0]         h1_ff, h1_in;
   logic [HW-1:0]         h2_ff, h2_in;
   logic [HW-1:0]         pw_ff, pw_in;
   logic [HW-1:0]         iv_ff, iv_in;
   logic [HW-1:0]         prev_ff, prev_in;
   logic                  sel_b_ff, sel_b_in;
   logic [HW-1:0]         base_ff;
   logic [HW-1:0]         binv_ff;

   prh_pkg::store_ctl_type st_ctl;
   prh_pkg::entry_type     st_wdata;
   prh_pkg::entry_type     st_rdata;
   logic                   mul_start;
   logic [HW-1:0]          mul_a;
   logic [HW-1:0]          mul_b;
   logic [HW-1:0]          mul_res;
   logic                   mul_done;

   logic [HW-1:0]  base_r;
   logic [HW-1:0]  binv_r;
   logic [IW-1:0]  cur_l;
   logic [IW-1:0]  cur_r;
   logic           bad_a;
   logic           bad_b;
   logic           accept;
   logic [IW-1:0]  p_new;
   logic [7:0]     sym_v;

   prh_store u_store (
      .clock (clock),
      .ctl   (st_ctl),
      .wdata (st_wdata),
      .rdata (st_rdata)
   );

   prh_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .result (mul_res),
      .done   (mul_done)
   );

   assign base_r    = prh_pkg::reduce(base_ff);
   assign binv_r    = prh_pkg::reduce(binv_ff);
   assign cur_l     = sel_b_ff ? item_ff.left_b : item_ff.left_a;
   assign cur_r     = sel_b_ff ? item_ff.right_b : item_ff.right_a;
   assign bad_a     = (req_item.right_a >= req_item.left_a) &&
                      ({1'b0, req_item.right_a} >= len_ff);
   assign bad_b     = (req_item.right_b >= req_item.left_b) &&
                      ({1'b0, req_item.right_b} >= len_ff);
   assign accept    = req_valid && !req_stall;
   assign req_stall = (fsm_ff != prh_pkg::FS_IDLE);
   assign p_new     = req_item.restart ? '0 : len_ff[IW-1:0];
   assign sym_v     = item_ff.symbol - prh_pkg::SYM_OFFSET;

   always_comb begin
      fsm_in       = fsm_ff;
      item_in      = item_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff;
      len_in       = len_ff;
      n1_in        = n1_ff;
      pos_in       = pos_ff;
      status_in    = status_ff;
      hash_in      = hash_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      pw_in        = pw_ff;
      iv_in        = iv_ff;
      prev_in      = prev_ff;
      sel_b_in     = sel_b_ff;
      st_ctl       = '0;
      st_wdata     = '0;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (fsm_ff)
         prh_pkg::FS_IDLE: begin
            if (accept) begin
               item_in   = req_item;
               sel_b_in  = 1'b0;
               status_in = prh_pkg::STATUS_OK;
               hash_in   = '0;
               pos_in    = '0;
               case (prh_pkg::op_type'(req_item.req_type))
                  prh_pkg::OP_APPEND: begin
                     if (req_item.symbol < prh_pkg::SYM_FIRST ||
                         req_item.symbol > prh_pkg::SYM_LAST) begin
                        status_in = prh_pkg::STATUS_BAD;
                        fsm_in    = prh_pkg::FS_DONE;
                     end else if (!req_item.restart && len_ff == prh_pkg::LEN_FULL) begin
                        status_in = prh_pkg::STATUS_FULL;
                        fsm_in    = prh_pkg::FS_DONE;
                     end else if (p_new == '0) begin
                        pos_in  = '0;
                        pw_in   = HW'(1);
                        iv_in   = HW'(1);
                        prev_in = '0;
                        fsm_in  = prh_pkg::FS_A_MV;
                     end else begin
                        pos_in = p_new;
                        fsm_in = prh_pkg::FS_A_RD;
                     end
                  end
                  prh_pkg::OP_RANGE: begin
                     if (bad_a) begin
                        status_in = prh_pkg::STATUS_BAD;
                        fsm_in    = prh_pkg::FS_DONE;
                     end else begin
                        fsm_in = prh_pkg::FS_R_START;
                     end
                  end
                  prh_pkg::OP_MERGE: begin
                     if (bad_a || bad_b) begin
                        status_in = prh_pkg::STATUS_BAD;
                        fsm_in    = prh_pkg::FS_DONE;
                     end else begin
                        fsm_in = prh_pkg::FS_R_START;
                     end
                  end
                  default: begin
                     status_in = prh_pkg::STATUS_BAD;
                     fsm_in    = prh_pkg::FS_DONE;
                  end
               endcase
            end
         end
         prh_pkg::FS_A_RD: begin
            st_ctl.raddr = pos_ff - 1'b1;
            fsm_in       = prh_pkg::FS_A_PW;
         end
         prh_pkg::FS_A_PW: begin
            prev_in   = st_rdata.prefix;
            iv_in     = st_rdata.inverse;
            mul_start = 1'b1;
            mul_a     = st_rdata.power;
            mul_b     = base_r;
            fsm_in    = prh_pkg::FS_A_WPW;
         end
         prh_pkg::FS_A_WPW: begin
            if (mul_done) begin
               pw_in     = mul_res;
               mul_start = 1'b1;
               mul_a     = iv_ff;
               mul_b     = binv_r;
               fsm_in    = prh_pkg::FS_A_WIV;
            end
         end
         prh_pkg::FS_A_WIV: begin
            if (mul_done) begin
               iv_in  = mul_res;
               fsm_in = prh_pkg::FS_A_MV;
            end
         end
         prh_pkg::FS_A_MV: begin
            mul_start = 1'b1;
            mul_a     = {{(HW-8){1'b0}}, sym_v};
            mul_b     = pw_ff;
            fsm_in    = prh_pkg::FS_A_WV;
         end
         prh_pkg::FS_A_WV: begin
            if (mul_done) begin
               hash_in          = prh_pkg::add_mod(prev_ff, mul_res);
               st_ctl.we        = 1'b1;
               st_ctl.waddr     = pos_ff;
               st_wdata.prefix  = prh_pkg::add_mod(prev_ff, mul_res);
               st_wdata.power   = pw_ff;
               st_wdata.inverse = iv_ff;
               len_in           = {1'b0, pos_ff} + 1'b1;
               fsm_in           = prh_pkg::FS_DONE;
            end
         end
         prh_pkg::FS_R_START: begin
            if (cur_r < cur_l) begin
               if (prh_pkg::op_type'(item_ff.req_type) == prh_pkg::OP_RANGE) begin
                  hash_in = '0;
                  fsm_in  = prh_pkg::FS_DONE;
               end else if (!sel_b_ff) begin
                  h1_in    = '0;
                  n1_in    = '0;
                  sel_b_in = 1'b1;
               end else begin
                  h2_in  = '0;
                  fsm_in = prh_pkg::FS_M_POW;
               end
            end else begin
               fsm_in = prh_pkg::FS_R_HI;
            end
         end
         prh_pkg::FS_R_HI: begin
            st_ctl.raddr = cur_r;
            fsm_in       = prh_pkg::FS_R_LO;
         end
         prh_pkg::FS_R_LO: begin
            hi_in        = st_rdata.prefix;
            st_ctl.raddr = cur_l - 1'b1;
            fsm_in       = prh_pkg::FS_R_INV;
         end
         prh_pkg::FS_R_INV: begin
            lo_in        = (cur_l == '0) ? '0 : st_rdata.prefix;
            st_ctl.raddr = cur_l;
            fsm_in       = prh_pkg::FS_R_MUL;
         end
         prh_pkg::FS_R_MUL: begin
            mul_start = 1'b1;
            mul_a     = prh_pkg::sub_mod(hi_ff, lo_ff);
            mul_b     = (cur_l == '0) ? HW'(1) : st_rdata.inverse;
            fsm_in    = prh_pkg::FS_R_WAIT;
         end
         prh_pkg::FS_R_WAIT: begin
            if (mul_done) begin
               if (prh_pkg::op_type'(item_ff.req_type) == prh_pkg::OP_RANGE) begin
                  hash_in = mul_res;
                  fsm_in  = prh_pkg::FS_DONE;
               end else if (!sel_b_ff) begin
                  h1_in    = mul_res;
                  n1_in    = {1'b0, cur_r} - {1'b0, cur_l} + 1'b1;
                  sel_b_in = 1'b1;
                  fsm_in   = prh_pkg::FS_R_START;
               end else begin
                  h2_in  = mul_res;
                  fsm_in = prh_pkg::FS_M_POW;
               end
            end
         end
         prh_pkg::FS_M_POW: begin
            if (n1_ff == '0) begin
               pw_in  = HW'(1);
               fsm_in = prh_pkg::FS_M_MUL;
            end else begin
               st_ctl.raddr = IW'(n1_ff - 1'b1);
               fsm_in       = prh_pkg::FS_M_PRD;
            end
         end
         prh_pkg::FS_M_PRD: begin
            mul_start = 1'b1;
            mul_a     = st_rdata.power;
            mul_b     = base_r;
            fsm_in    = prh_pkg::FS_M_WPW;
         end
         prh_pkg::FS_M_WPW: begin
            if (mul_done) begin
               pw_in  = mul_res;
               fsm_in = prh_pkg::FS_M_MUL;
            end
         end
         prh_pkg::FS_M_MUL: begin
            mul_start = 1'b1;
            mul_a     = h2_ff;
            mul_b     = pw_ff;
            fsm_in    = prh_pkg::FS_M_WAIT;
         end
         prh_pkg::FS_M_WAIT: begin
            if (mul_done) begin
               hash_in = prh_pkg::add_mod(h1_ff, mul_res);
               fsm_in  = prh_pkg::FS_DONE;
            end
         end
         prh_pkg::FS_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_item_in.hash_value = hash_ff;
               rsp_item_in.position   = pos_ff;
               rsp_item_in.status     = status_ff;
               fsm_in                 = prh_pkg::FS_IDLE;
            end
         end
         default: begin
            fsm_in = prh_pkg::FS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= prh_pkg::FS_IDLE;
         rsp_valid_ff <= 1'b0;
         len_ff       <= '0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
      end
      item_ff     <= item_in;
      rsp_item_ff <= rsp_item_in;
      n1_ff       <= n1_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      hash_ff     <= hash_in;
      hi_ff       <= hi_in;
      lo_ff       <= lo_in;
      h1_ff       <= h1_in;
      h2_ff       <= h2_in;
      pw_ff       <= pw_in;
      iv_ff       <= iv_in;
      prev_ff     <= prev_in;
      sel_b_ff    <= sel_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= prh_pkg::BASE_RESET;
         binv_ff <= prh_pkg::INV_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            prh_pkg::REG_HASH_BASE: base_ff <= csr_wdata;
            prh_pkg::REG_BASE_INV:  binv_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `ASSERT_ALWAYS(a_len_bound, len_ff <= prh_pkg::LEN_FULL, "string length beyond store")
   `ASSERT_ALWAYS(a_write_append, st_ctl.we |-> (fsm_ff == prh_pkg::FS_A_WV),
                  "store write outside append")
   `ASSERT_ALWAYS(a_reject_zero,
                  rsp_valid && rsp_item.status != prh_pkg::STATUS_OK |->
                  rsp_item.hash_value == '0,
                  "rejected item with nonzero hash")
   `ASSERT_NEXT(a_len_idle, fsm_ff == prh_pkg::FS_IDLE, $stable(len_ff), "length changed while idle")

endmodule
